// File: rtl/bra_pkg.sv
// Shared definitions for the bitmap run allocator: field widths, mode codes,
// payload structs and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package bra_pkg;

  localparam int MAX_BITS_DEF = 4096;

  localparam int CFG_W = 13;  // bits_in_use and any bit count
  localparam int POS_W = 12;  // position and start_index fields
  localparam int LEN_W = 13;  // run_length field
  localparam int IDX_W = 14;  // bit index arithmetic with headroom for pos + len

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  localparam logic [1:0] MODE_FILL  = 2'd0;
  localparam logic [1:0] MODE_GET   = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;
  localparam logic [1:0] MODE_ALLOC = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] run_length;
    logic             bit_value;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] start_index;
    logic             read_bit;
  } out_item_t;

  typedef struct packed {
    logic load;     // capture a new request
    logic clr_wr;   // write zero at the sweep address, advance
    logic fill_wr;  // write the fill byte, advance
    logic rd_byte;  // read the byte at the current address
    logic get_cap;  // capture the addressed bit into the result
    logic set_wr;   // write back the modified byte, advance
    logic scan;     // one step of the run search
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic fill_end;
    logic range_empty;
    logic set_last;
    logic scan_hit;
    logic scan_done;
    logic len_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/bitmap_run_allocator.sv
// Bitmap run allocator: a first-fit allocator over a map of up to MAX_BITS bits,
// held as MAX_BITS/8 bytes in a single-port memory, one byte accessed per clock.
// The block handles one request at a time. After reset a clearing pass zeroes
// every byte, during which in_stall stays high. Fill writes every byte in use,
// get reads one byte, a range write reads and rewrites each byte it touches, and
// allocate scans the bytes in use and, when it finds a run, inverts that run
// through the range writer unless the requested length is zero. The result sits
// in an output register, so the next request is taken as soon as it has been
// handed over.
// Uses bra_pkg, bra_ctrl and bra_dp.
`default_nettype none

module bitmap_run_allocator #(
  parameter int MAX_BITS = bra_pkg::MAX_BITS_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire bra_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output bra_pkg::out_item_t        out_data,
  input  wire                       cfg_wr_en,
  input  wire [bra_pkg::CFG_W-1:0]  cfg_wr_data
);
  import bra_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_item_t res;
  logic      emit;
  logic      out_free;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign out_free = !out_valid_r || !out_stall;

  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .out_free (out_free),
    .emit     (emit),
    .cmd      (cmd),
    .sts      (sts)
  );

  bra_dp #(
    .MAX_BITS (MAX_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/bra_dp.sv
// Datapath of the bitmap run allocator: byte-wide map memory, address sweep,
// range masking, run search and the result register. Uses bra_pkg.
`default_nettype none

module bra_dp #(
  parameter int MAX_BITS = bra_pkg::MAX_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire bra_pkg::dp_cmd_t        cmd,
  output bra_pkg::dp_sts_t             sts,
  input  wire bra_pkg::in_item_t       in_data,
  input  wire                          cfg_wr_en,
  input  wire [bra_pkg::CFG_W-1:0]     cfg_wr_data,
  output bra_pkg::out_item_t           res
);
  import bra_pkg::*;

  localparam int DEPTH = (MAX_BITS + 7) / 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int NBW   = CFG_W - 2;
  localparam int CMPW  = (CW > NBW) ? CW : NBW;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata_r;
  logic [CFG_W-1:0] bits_r;
  logic [CW-1:0]    addr_r;
  logic [CFG_W-1:0] pos_r;
  logic [LEN_W-1:0] len_r;
  logic             val_r;
  logic [IDX_W-1:0] end_r;
  logic [CFG_W-1:0] run_r;
  logic             scan_vld_r;
  logic [CW-1:0]    scan_byte_r;
  out_item_t        res_r;

  logic [CFG_W-1:0] n;
  logic [NBW-1:0]   nbytes;
  logic [IDX_W-1:0] end_nxt;
  logic [IDX_W-1:0] sum;
  logic [LEN_W-1:0] need;
  logic [7:0]       smask;
  logic [7:0]       set_byte;
  logic             hit;
  logic [IDX_W-1:0] hit_start;
  logic [CFG_W-1:0] run_out;
  logic             fill_end;
  logic             mem_we;
  logic             mem_re;
  logic [7:0]       wdata;

  // Managed size saturates at the map capacity
  assign n        = (32'(bits_r) > MAX_BITS) ? CFG_W'(MAX_BITS) : bits_r;
  assign nbytes   = NBW'((IDX_W'(n) + IDX_W'(7)) >> 3);
  assign fill_end = CMPW'(addr_r) >= CMPW'(nbytes);
  assign need     = (len_r == '0) ? LEN_W'(1) : len_r;
  assign sum      = IDX_W'(pos_r) + IDX_W'(len_r);
  assign end_nxt  = (sum > IDX_W'(n)) ? IDX_W'(n) : sum;

  always_comb begin : set_mask
    logic [IDX_W-1:0] bi;
    bi = '0;
    for (int j = 0; j < 8; j++) begin
      bi       = (IDX_W'(addr_r) << 3) | IDX_W'(j);
      smask[j] = (bi >= IDX_W'(pos_r)) && (bi < end_r);
    end
    set_byte = val_r ? (rdata_r | smask) : (rdata_r & ~smask);
  end

  // Run search over one byte: bits past the map end never match
  always_comb begin : run_search
    logic [IDX_W-1:0] bi;
    logic [IDX_W-1:0] runj;
    logic [3:0]       loc;
    logic             all;
    logic             m;
    bi        = '0;
    runj      = '0;
    loc       = '0;
    all       = 1'b1;
    m         = 1'b0;
    hit       = 1'b0;
    hit_start = '0;
    for (int j = 0; j < 8; j++) begin
      bi   = (IDX_W'(scan_byte_r) << 3) | IDX_W'(j);
      m    = (rdata_r[j] == val_r) && (bi < IDX_W'(n));
      loc  = m ? loc + 4'd1 : 4'd0;
      all  = all & m;
      runj = all ? IDX_W'(run_r) + IDX_W'(loc) : IDX_W'(loc);
      if (!hit && (runj >= IDX_W'(need))) begin
        hit       = 1'b1;
        hit_start = bi + IDX_W'(1) - IDX_W'(need);
      end
    end
    run_out = CFG_W'(runj);
  end

  assign sts.clr_last    = addr_r == CW'(DEPTH - 1);
  assign sts.fill_end    = fill_end;
  assign sts.range_empty = (pos_r >= n) || (len_r == '0);
  assign sts.set_last    = CMPW'(addr_r) == CMPW'((end_r - IDX_W'(1)) >> 3);
  assign sts.scan_hit    = scan_vld_r && hit;
  assign sts.scan_done   = !scan_vld_r && fill_end;
  assign sts.len_zero    = len_r == '0;

  assign mem_we = cmd.clr_wr | cmd.fill_wr | cmd.set_wr;
  assign mem_re = cmd.rd_byte | (cmd.scan && !fill_end);

  always_comb begin
    priority if (cmd.clr_wr) begin
      wdata = 8'h00;
    end else if (cmd.fill_wr) begin
      wdata = {8{val_r}};
    end else begin
      wdata = set_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r[AW-1:0]] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[addr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      bits_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= '0;
      scan_vld_r <= 1'b0;
    end else begin
      priority if (cmd.load) begin
        scan_vld_r <= 1'b0;
        if (in_data.mode == MODE_GET || in_data.mode == MODE_SET) begin
          addr_r <= CW'(in_data.position >> 3);
        end else begin
          addr_r <= '0;
        end
      end else if (cmd.clr_wr || cmd.fill_wr || cmd.set_wr) begin
        addr_r <= addr_r + CW'(1);
      end else if (cmd.scan) begin
        if (sts.scan_hit) begin
          addr_r     <= CW'(hit_start >> 3);
          scan_vld_r <= 1'b0;
        end else begin
          scan_vld_r <= !fill_end;
          if (!fill_end) begin
            addr_r <= addr_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    end_r <= end_nxt;
    if (cmd.load) begin
      pos_r <= CFG_W'(in_data.position);
      len_r <= in_data.run_length;
      val_r <= in_data.bit_value;
      run_r <= '0;
      res_r <= '{ok: 1'b1, start_index: '0, read_bit: 1'b0};
    end else if (cmd.get_cap) begin
      res_r.read_bit <= (pos_r < n) ? rdata_r[pos_r[2:0]] : 1'b0;
    end else if (cmd.scan) begin
      scan_byte_r <= addr_r;
      if (sts.scan_hit) begin
        // Reuse the range writer to invert the run just found
        pos_r             <= CFG_W'(hit_start);
        val_r             <= ~val_r;
        res_r.start_index <= POS_W'(hit_start);
      end else if (sts.scan_done) begin
        res_r.ok <= 1'b0;
      end else if (scan_vld_r) begin
        run_r <= run_out;
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// File: rtl/bra_ctrl.sv
// Controller of the bitmap run allocator: sequences clearing, fill, get, range
// write and run search through the datapath. Uses bra_pkg.
`default_nettype none

module bra_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  wire [1:0]              in_mode,
  output logic                   in_stall,
  input  wire                    out_free,
  output logic                   emit,
  output bra_pkg::dp_cmd_t       cmd,
  input  wire bra_pkg::dp_sts_t  sts
);
  import bra_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd2;
  localparam logic [3:0] S_GRD   = 4'd3;
  localparam logic [3:0] S_GCAP  = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SWR   = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    emit      = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_mode)
            MODE_FILL:  state_nxt = S_FILL;
            MODE_GET:   state_nxt = S_GRD;
            MODE_SET:   state_nxt = S_SRD;
            MODE_ALLOC: state_nxt = S_SCAN;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        if (sts.fill_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.fill_wr = 1'b1;
        end
      end
      S_GRD: begin
        cmd.rd_byte = 1'b1;
        state_nxt   = S_GCAP;
      end
      S_GCAP: begin
        cmd.get_cap = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SRD: begin
        if (sts.range_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_byte = 1'b1;
          state_nxt   = S_SWR;
        end
      end
      S_SWR: begin
        cmd.set_wr = 1'b1;
        state_nxt  = sts.set_last ? S_DONE : S_SRD;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit) begin
          state_nxt = sts.len_zero ? S_DONE : S_SRD;
        end else if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register can take it
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: bench/tb_bitmap_run_allocator.sv
// Testbench for bitmap_run_allocator: directed and random requests over many map
// sizes, checked against an in-bench bitmap predictor held by a scoreboard class.
// Depends on bra_pkg and the bitmap_run_allocator RTL.
module tb_bitmap_run_allocator;
  import bra_pkg::*;

  localparam int MAP_BITS = 4096;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int NUM_PHASES = 12;

  class bitmap_scoreboard;
    bit          map_bits[MAP_BITS];
    int unsigned size_cfg;
    out_item_t   pending_replies[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned alloc_hits;
    int unsigned alloc_misses;
    int unsigned last_start;
    int unsigned last_len;
    bit          last_free;

    function new();
      foreach (map_bits[i]) map_bits[i] = 1'b0;
      size_cfg = CFG_RESET;
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      size_cfg = v;
    endfunction

    function void write_span(int unsigned start, int unsigned count, bit v, int unsigned n);
      for (int unsigned k = 0; k < count && start < n; k++, start++) map_bits[start] = v;
    endfunction

    // Advance the map by one transaction and queue the reply it must produce.
    function void note_request(in_item_t req);
      int unsigned n;
      int unsigned need;
      int unsigned run;
      int unsigned top;
      int unsigned first;
      bit hit;
      out_item_t want;
      n = (size_cfg > MAP_BITS) ? MAP_BITS : size_cfg;
      want = '0;
      want.ok = 1'b1;
      case (req.mode)
        MODE_FILL: begin
          // whole bytes: the tail of the last partial byte is written too
          top = ((n + 7) / 8) * 8;
          for (int unsigned i = 0; i < top; i++) map_bits[i] = req.bit_value;
        end
        MODE_GET: begin
          if (req.position < n) want.read_bit = map_bits[req.position];
        end
        MODE_SET: begin
          write_span(req.position, req.run_length, req.bit_value, n);
        end
        default: begin
          need = (req.run_length == 0) ? 1 : req.run_length;
          run = 0;
          hit = 1'b0;
          first = 0;
          for (int unsigned i = 0; i < n && !hit; i++) begin
            if (map_bits[i] == req.bit_value) begin
              run++;
              if (run == need) begin
                hit = 1'b1;
                first = i + 1 - need;
              end
            end else begin
              run = 0;
            end
          end
          if (hit) begin
            alloc_hits++;
            want.start_index = first[POS_W-1:0];
            if (req.run_length != 0) begin
              write_span(first, req.run_length, ~req.bit_value, n);
              last_start = first;
              last_len = req.run_length;
              last_free = req.bit_value;
            end
          end else begin
            alloc_misses++;
            want.ok = 1'b0;
          end
        end
      endcase
      pending_replies.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual ok=%0b start_index=%0d read_bit=%0b",
                 $time, got.ok, got.start_index, got.read_bit);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (got.ok !== want.ok) begin
        $display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, got.ok);
        errors++;
      end
      if (got.start_index !== want.start_index) begin
        $display("%0t: start_index mismatch: expected %0d, actual %0d",
                 $time, want.start_index, got.start_index);
        errors++;
      end
      if (got.read_bit !== want.read_bit) begin
        $display("%0t: read_bit mismatch: expected %0b, actual %0b",
                 $time, want.read_bit, got.read_bit);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  bitmap_scoreboard sb;
  bit               idle_on = 1'b0;
  bit               hold_off_req = 1'b0;
  int unsigned      phase_size[NUM_PHASES];
  int unsigned      phase_items;

  bitmap_run_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  initial begin
    #25_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offer one transaction; leave valid high on return so the next can follow at once.
  task automatic send_request(input in_item_t req);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [1:0] mode, input int unsigned pos,
                         input int unsigned len, input bit v);
    in_item_t req;
    req.mode = mode;
    req.position = pos[POS_W-1:0];
    req.run_length = len[LEN_W-1:0];
    req.bit_value = v;
    send_request(req);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_size(input int unsigned v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v[CFG_W-1:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_size(v[CFG_W-1:0]);
  endtask

  function automatic int unsigned pick_length(int unsigned span);
    int unsigned cap;
    cap = (span < 64) ? span : span / 8;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return span;
      2: return (span < MAP_BITS) ? span + 1 : MAP_BITS;
      3: return $urandom_range(0, MAP_BITS);
      default: return $urandom_range(1, cap);
    endcase
  endfunction

  // Mostly in-map positions and short runs, with frees of the last grant mixed in.
  task automatic send_random(input int unsigned size);
    int unsigned n;
    int unsigned span;
    int unsigned pick;
    int unsigned pos;
    bit v;
    n = (size > MAP_BITS) ? MAP_BITS : size;
    span = (n == 0) ? 1 : n;
    v = $urandom_range(0, 1);
    pos = (n != 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, span - 1)
                                                 : $urandom_range(0, MAP_BITS - 1);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_op(MODE_FILL, pos, pick_length(span), v);
    end else if (pick < 30) begin
      send_op(MODE_GET, pos, pick_length(span), v);
    end else if (pick < 42 && sb.last_len != 0) begin
      send_op(MODE_SET, sb.last_start, sb.last_len, sb.last_free);
    end else if (pick < 55) begin
      send_op(MODE_SET, pos, pick_length(span), v);
    end else begin
      send_op(MODE_ALLOC, pos, pick_length(span), v);
    end
  endtask

  initial begin
    sb = new();
    phase_size = '{64, 1, 200, 37, 4096, 8, 512, 1000, 9, 8191, 300, 129};
    phase_size[3] = $urandom_range(2, 255);
    phase_size[8] = $urandom_range(2, 40);
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    // hold off until the clearing pass is done
    while (in_stall) @(negedge clk);

    write_size(4096);
    send_op(MODE_GET, 4095, 0, 1'b0);
    send_op(MODE_ALLOC, 0, 0, 1'b1);
    send_op(MODE_ALLOC, 0, 0, 1'b0);
    send_op(MODE_ALLOC, 0, 4096, 1'b0);
    send_op(MODE_SET, 4095, 4096, 1'b0);
    send_op(MODE_ALLOC, 0, 1, 1'b0);
    send_op(MODE_ALLOC, 0, 1, 1'b0);
    send_op(MODE_SET, 100, 20, 1'b0);
    send_op(MODE_ALLOC, 0, 21, 1'b0);
    send_op(MODE_ALLOC, 0, 20, 1'b0);
    send_op(MODE_FILL, 0, 0, 1'b0);
    send_op(MODE_SET, 2048, 0, 1'b1);
    send_op(MODE_GET, 2048, 0, 1'b0);
    // empty map
    write_size(0);
    send_op(MODE_FILL, 0, 0, 1'b1);
    send_op(MODE_GET, 0, 0, 1'b0);
    send_op(MODE_ALLOC, 0, 0, 1'b0);
    // size above the maximum
    write_size(8191);
    send_op(MODE_ALLOC, 0, 4096, 1'b0);
    send_op(MODE_GET, 4095, 0, 1'b0);
    // partial last byte, read past the end, run longer than the map
    write_size(13);
    send_op(MODE_FILL, 0, 0, 1'b1);
    send_op(MODE_GET, 13, 0, 1'b0);
    send_op(MODE_ALLOC, 0, 14, 1'b1);
    write_size(16);
    send_op(MODE_GET, 14, 0, 1'b0);
    write_size(1);
    send_op(MODE_ALLOC, 0, 1, 1'b0);
    send_op(MODE_SET, 0, 3, 1'b0);
    send_op(MODE_ALLOC, 0, 1, 1'b0);

    idle_on = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_size(phase_size[p]);
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      phase_items = (phase_size[p] >= 1000) ? 60 : 110;
      for (int k = 0; k < phase_items; k++) begin
        if (p == 2 && k == 40) hold_off_req = 1'b1;
        if (p == 6 && k == 50) wait_drained();
        send_random(phase_size[p]);
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("Checked %0d results over %0d map sizes plus directed corner cases;",
             sb.checked, NUM_PHASES);
    $display("first-fit allocations granted %0d, refused %0d.", sb.alloc_hits, sb.alloc_misses);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
